>>> hw/rtl/nwam_pkg.sv
// Shared types, constants and the divider step for the weighted audio mixer.
// No dependencies; every other mixer file but the checker imports this package.
`default_nettype none
package nwam_pkg;

  localparam int LANES     = 4;
  localparam int SW        = 16;
  localparam int SUMW      = 18;
  localparam int MAGW      = 31;
  localparam int DIV_STEPS = MAGW;
  localparam int ACCW      = 34;
  localparam int CFG_IDXW  = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTRW     = 2;
  localparam int QCNTW     = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDXW-1:0] REG_WEIGHT_0 = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_ENABLE   = 3'd4;

  // One classified item between the front end and the back end
  typedef struct packed {
    logic                       is_mix;
    logic [SW-1:0]              pass_val;
    logic                       frame_end;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0][MAGW-1:0] mag;
  } mix_item_t;

  // One stage of the long-division pipeline
  typedef struct packed {
    logic                       valid;
    logic                       is_mix;
    logic [SW-1:0]              pass_val;
    logic                       frame_end;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0][MAGW-1:0] a;
    logic [LANES-1:0][SUMW-1:0] r;
  } div_stage_t;

  // Accumulated contributions, ahead of saturation
  typedef struct packed {
    logic                   valid;
    logic                   is_mix;
    logic [SW-1:0]          pass_val;
    logic                   frame_end;
    logic signed [ACCW-1:0] acc;
  } acc_stage_t;

  // Magnitude of a 16-bit two's complement value
  function automatic logic [SW:0] mag16(logic [SW-1:0] v);
    logic [SW:0] x;
    x = {v[SW-1], v};
    return v[SW-1] ? (~x + (SW+1)'(1)) : x;
  endfunction

  // One restoring-division step on every lane: shift in a dividend bit,
  // try to subtract the divisor, shift the quotient bit in at the bottom
  function automatic div_stage_t div_step(div_stage_t s, logic [SUMW-1:0] d);
    div_stage_t  o;
    logic [SUMW:0]   rs;
    logic [SUMW+1:0] diff;
    logic            qb;
    o = s;
    for (int k = 0; k < LANES; k++) begin
      rs   = {s.r[k], s.a[k][MAGW-1]};
      diff = {1'b0, rs} - {2'b00, d};
      qb   = ~diff[SUMW+1];
      o.r[k] = qb ? diff[SUMW-1:0] : rs[SUMW-1:0];
      o.a[k] = {s.a[k][MAGW-2:0], qb};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/normalized_weighted_audio_mixer_core.sv
// Weighted audio mixer with weight-sum normalization.
// Usage:
//   Configuration: cfg_we writes cfg_data to register cfg_index (0..3 are
//   the signed weights of inputs zero to three, 4 is the mixer enable).
//   Write only while the block holds no item.
//   Input channel: in_valid / in_stall, one beat per sample position with
//   four samples, a present mask and a frame-end flag.
//   Output channel: out_valid / out_stall, one beat per input beat, in order.
// Path from input accept to out_valid: the queue entry is written at the
//   accepting edge, then 31 long-division stages (one quotient bit each),
//   one accumulate stage and the output register follow.
// Throughput: one beat per cycle while no held output beat is stalled; the
//   division pipeline advances once per cycle as a whole unless so stalled.
// Reset: weights clear to 0, enable sets to 1, queue and pipeline empty.
// Receiver stall: output beat holds, pipeline freezes, the four-entry
//   queue absorbs input until full, then in_stall rises.
// Depends on nwam_pkg, nwam_front, nwam_queue, nwam_back.
`default_nettype none
module normalized_weighted_audio_mixer_core import nwam_pkg::*; #(
  parameter int NUM_INPUTS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CFG_IDXW-1:0] cfg_index,
  input  wire logic [SW-1:0]       cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SW-1:0]       in_sample_a,
  input  wire logic [SW-1:0]       in_sample_b,
  input  wire logic [SW-1:0]       in_sample_c,
  input  wire logic [SW-1:0]       in_sample_d,
  input  wire logic [LANES-1:0]    in_present_mask,
  input  wire logic                in_frame_end,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SW-1:0]            out_mixed_sample,
  output logic                     out_frame_end_out
);

  mix_item_t       item;
  mix_item_t       q_head;
  logic [SUMW-1:0] wsum;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  nwam_front #(.NUM_INPUTS(NUM_INPUTS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_sample_a, .in_sample_b, .in_sample_c, .in_sample_d,
    .in_present_mask, .in_frame_end,
    .item, .wsum
  );

  nwam_queue u_queue (
    .clk, .rst_n, .push, .din(item), .pop(q_pop), .dout(q_head),
    .empty(q_empty), .full(q_full)
  );

  nwam_back u_back (
    .clk, .rst_n, .wsum, .q_empty, .q_head, .q_pop,
    .out_valid, .out_stall, .out_mixed_sample, .out_frame_end_out
  );

endmodule
`default_nettype wire

>>> hw/rtl/nwam_front.sv
// Front end: weight registers, weight magnitude sum, item classification
// and per-lane magnitude products. Depends on nwam_pkg.
`default_nettype none
module nwam_front import nwam_pkg::*; #(
  parameter int NUM_INPUTS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CFG_IDXW-1:0] cfg_index,
  input  wire logic [SW-1:0]       cfg_data,
  input  wire logic [SW-1:0]       in_sample_a,
  input  wire logic [SW-1:0]       in_sample_b,
  input  wire logic [SW-1:0]       in_sample_c,
  input  wire logic [SW-1:0]       in_sample_d,
  input  wire logic [LANES-1:0]    in_present_mask,
  input  wire logic                in_frame_end,
  output mix_item_t                item,
  output logic [SUMW-1:0]          wsum
);

  localparam int USED = (NUM_INPUTS < LANES) ? NUM_INPUTS : LANES;

  logic [SW-1:0]   w_r [LANES];
  logic            en_r;
  logic [SUMW-1:0] sum_r;
  logic [SUMW-1:0] sum_nxt;
  logic [SW-1:0]   smp [LANES];

  assign smp[0] = in_sample_a;
  assign smp[1] = in_sample_b;
  assign smp[2] = in_sample_c;
  assign smp[3] = in_sample_d;
  assign wsum   = sum_r;

  // Recompute the magnitude sum with the incoming weight in place
  always_comb begin
    logic [SW-1:0] wk;
    sum_nxt = '0;
    for (int k = 0; k < USED; k++) begin
      wk = (cfg_index == (REG_WEIGHT_0 + CFG_IDXW'(k))) ? cfg_data : w_r[k];
      sum_nxt = sum_nxt + SUMW'(mag16(wk));
    end
  end

  // Take configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANES; k++) w_r[k] <= '0;
      en_r  <= 1'b1;
      sum_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index < REG_ENABLE) begin
        w_r[cfg_index[QPTRW-1:0]] <= cfg_data;
        sum_r <= sum_nxt;
      end else if (cfg_index == REG_ENABLE) begin
        en_r <= cfg_data[0];
      end
    end
  end

  // Classify: silence, pass-through, single source, or full mix;
  // form |sample * weight| and its sign on every lane in use
  always_comb begin
    logic            found;
    logic [SW:0]     sm;
    logic [SW:0]     wm;
    logic [2*SW-1:0] prod;
    found          = 1'b0;
    item.is_mix    = 1'b0;
    item.pass_val  = '0;
    item.frame_end = in_frame_end;
    priority if (sum_r == '0) begin
      item.pass_val = '0;
    end else if (!en_r) begin
      item.pass_val = in_present_mask[0] ? smp[0] : '0;
    end else if (sum_r == SUMW'(1)) begin
      for (int k = 0; k < USED; k++) begin
        if (!found && w_r[k] != '0) begin
          found         = 1'b1;
          item.pass_val = in_present_mask[k] ? smp[k] : '0;
        end
      end
    end else begin
      item.is_mix = 1'b1;
    end
    for (int k = 0; k < LANES; k++) begin
      sm   = mag16(smp[k]);
      wm   = mag16(w_r[k]);
      prod = sm[SW-1:0] * wm[SW-1:0];
      item.neg[k] = smp[k][SW-1] ^ w_r[k][SW-1];
      if (k < USED && in_present_mask[k] && w_r[k] != '0) begin
        item.mag[k] = prod[MAGW-1:0];
      end else begin
        item.mag[k] = '0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/nwam_queue.sv
// Short FIFO of classified items between front end and back end.
// Depends on nwam_pkg for the item type and depth.
`default_nettype none
module nwam_queue import nwam_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  mix_item_t din,
  input  wire logic pop,
  output mix_item_t dout,
  output logic      empty,
  output logic      full
);

  mix_item_t        mem [QDEPTH];
  logic [QPTRW-1:0] wr_ptr_r;
  logic [QPTRW-1:0] rd_ptr_r;
  logic [QCNTW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNTW'(QDEPTH));
  assign dout  = mem[rd_ptr_r];

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= din;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTRW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTRW'(1);
      cnt_r <= cnt_r + QCNTW'(push) - QCNTW'(pop);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/nwam_back.sv
// Back end: pipelined long division per lane, accumulation, saturation
// and the output register. Depends on nwam_pkg.
`default_nettype none
module nwam_back import nwam_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [SUMW-1:0] wsum,
  input  wire logic            q_empty,
  input  mix_item_t            q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [SW-1:0]        out_mixed_sample,
  output logic                 out_frame_end_out
);

  div_stage_t st_r   [DIV_STEPS];
  div_stage_t st_nxt [DIV_STEPS];
  div_stage_t head;
  acc_stage_t acc_r;
  acc_stage_t acc_nxt;
  logic       out_valid_r;
  logic [SW-1:0] out_sample_r;
  logic       out_fe_r;
  logic       adv;

  // Whole pipeline moves unless a result is held by the receiver
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign out_valid         = out_valid_r;
  assign out_mixed_sample  = out_sample_r;
  assign out_frame_end_out = out_fe_r;

  // Load the queue head with a cleared remainder
  always_comb begin
    head.valid     = !q_empty;
    head.is_mix    = q_head.is_mix;
    head.pass_val  = q_head.pass_val;
    head.frame_end = q_head.frame_end;
    head.neg       = q_head.neg;
    head.a         = q_head.mag;
    head.r         = '0;
  end

  // One quotient bit per stage
  always_comb begin
    st_nxt[0] = div_step(head, wsum);
    for (int i = 1; i < DIV_STEPS; i++) st_nxt[i] = div_step(st_r[i-1], wsum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STEPS; i++) st_r[i].valid <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < DIV_STEPS; i++) st_r[i] <= st_nxt[i];
    end
  end

  // Sum the signed quotients
  always_comb begin
    logic signed [ACCW-1:0] q;
    acc_nxt.valid     = st_r[DIV_STEPS-1].valid;
    acc_nxt.is_mix    = st_r[DIV_STEPS-1].is_mix;
    acc_nxt.pass_val  = st_r[DIV_STEPS-1].pass_val;
    acc_nxt.frame_end = st_r[DIV_STEPS-1].frame_end;
    acc_nxt.acc       = '0;
    for (int k = 0; k < LANES; k++) begin
      q = $signed({{(ACCW-MAGW){1'b0}}, st_r[DIV_STEPS-1].a[k]});
      acc_nxt.acc = st_r[DIV_STEPS-1].neg[k] ? (acc_nxt.acc - q) : (acc_nxt.acc + q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r.valid <= 1'b0;
    end else if (adv) begin
      acc_r <= acc_nxt;
    end
  end

  // Saturate into the output register; hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= acc_r.valid;
      out_fe_r    <= acc_r.frame_end;
      priority if (!acc_r.is_mix) begin
        out_sample_r <= acc_r.pass_val;
      end else if (acc_r.acc > ACCW'(signed'(32767))) begin
        out_sample_r <= 16'h7fff;
      end else if (acc_r.acc < -ACCW'(signed'(32768))) begin
        out_sample_r <= 16'h8000;
      end else begin
        out_sample_r <= acc_r.acc[SW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/nwam_checker.sv
// Port-level checks for the mixer core, attached by bind.
// Depends on the top level's port names only.
`default_nettype none
module nwam_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_mixed_sample,
  input wire logic        out_frame_end_out
);

  // A held result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("output beat dropped");

  // A held result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_mixed_sample) && $stable(out_frame_end_out))
    else $error("held output beat changed");

  // Reset empties the pipeline
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Reset empties the queue
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind normalized_weighted_audio_mixer_core nwam_checker u_nwam_checker (.*);
`default_nettype wire
